[design/ctf_pkg.sv]
// Package for the chain temperature fan regulator.
// Holds codes, field widths, constants, structs and the duty polarity function.
// No dependencies; every other design file imports it.
package ctf_pkg;

	localparam int CODE_W  = 12;
	localparam int SPEED_W = 7;
	localparam int INDEX_W = 3;

	localparam logic [SPEED_W-1:0] STEP_SPEED = 7'd5;
	localparam logic [SPEED_W-1:0] MIN_SPEED  = 7'd10;
	localparam logic [SPEED_W-1:0] MAX_SPEED  = 7'd100;
	localparam logic [CODE_W-1:0]  DEADBAND   = 12'd3;
	localparam logic [CODE_W-1:0]  MOVE_MIN   = 12'd2;
	localparam logic [1:0]         HOLD_MAX   = 2'd3;

	// Configuration register indexes
	typedef enum logic [INDEX_W-1:0] {
		REG_HOT_LIMIT,
		REG_COOL_LIMIT,
		REG_DANGER,
		REG_TARGET,
		REG_DEFAULT_SPEED,
		REG_PWM_INV
	} reg_idx_t;

	typedef struct packed {
		logic [CODE_W-1:0]  hot_limit;
		logic [CODE_W-1:0]  cool_limit;
		logic [CODE_W-1:0]  danger;
		logic [CODE_W-1:0]  target;
		logic [SPEED_W-1:0] default_speed;
		logic               pwm_inverted;
	} cfg_t;

	typedef struct packed {
		logic              chain_absent;
		logic [CODE_W-1:0] high_read_a;
		logic [CODE_W-1:0] high_read_b;
		logic [CODE_W-1:0] high_read_c;
		logic [CODE_W-1:0] low_read_a;
		logic [CODE_W-1:0] low_read_b;
		logic [CODE_W-1:0] low_read_c;
		logic [CODE_W-1:0] average_read;
		logic              round_end;
	} item_t;

	// Per-chain verdict handed from the chain checker to the regulator
	typedef struct packed {
		logic              error;
		logic              update;
		logic              shutdown;
		logic [CODE_W-1:0] hot;
	} chain_res_t;

	typedef struct packed {
		logic               duty_valid;
		logic [SPEED_W-1:0] fan_duty;
	} duty_t;

	// Apply output polarity to a speed percent
	function automatic logic [SPEED_W-1:0] polarity(input logic inv,
			input logic [SPEED_W-1:0] speed);
		return inv ? (MAX_SPEED - speed) : speed;
	endfunction

endpackage

[design/ctf_in_if.sv]
// Input channel of the chain temperature fan regulator: one chain report per beat.
// Depends on ctf_pkg for field widths.
interface ctf_in_if import ctf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              chain_absent;
	logic [CODE_W-1:0] high_read_a;
	logic [CODE_W-1:0] high_read_b;
	logic [CODE_W-1:0] high_read_c;
	logic [CODE_W-1:0] low_read_a;
	logic [CODE_W-1:0] low_read_b;
	logic [CODE_W-1:0] low_read_c;
	logic [CODE_W-1:0] average_read;
	logic              round_end;

	modport source (output valid, chain_absent, high_read_a, high_read_b, high_read_c,
		low_read_a, low_read_b, low_read_c, average_read, round_end, input ready);
	modport sink (input valid, chain_absent, high_read_a, high_read_b, high_read_c,
		low_read_a, low_read_b, low_read_c, average_read, round_end, output ready);
endinterface

[design/ctf_out_if.sv]
// Output channel of the chain temperature fan regulator: one result per beat.
// Depends on ctf_pkg for field widths.
interface ctf_out_if import ctf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               chain_error;
	logic               chain_shutdown;
	logic               duty_valid;
	logic [SPEED_W-1:0] fan_duty;

	modport source (output valid, chain_error, chain_shutdown, duty_valid, fan_duty,
		input ready);
	modport sink (input valid, chain_error, chain_shutdown, duty_valid, fan_duty,
		output ready);
endinterface

[design/chain_temperature_fan_regulator_top.sv]
// Top level of the chain temperature fan regulator.
// Depends on ctf_pkg, ctf_in_if, ctf_out_if, ctf_chain_eval and ctf_regulator.
//
// One chain report is accepted per clock cycle while the output side is not stalled, and
// every report yields exactly one result: it is held in the input register, then the
// window checks and the loop update run in a single pass into the result register.
// in.ready follows out.ready combinationally, so a stalled output holds at most one
// result and one report.
// Configuration writes (index 0..5, data in the low bits of cfg_data) are taken at once
// and belong in idle periods; writing the cool limit also restarts the round figure.
module chain_temperature_fan_regulator_top import ctf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]  cfg_data,
	ctf_in_if.sink             in_ch,
	ctf_out_if.source          out_ch
);

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       err_q;
	logic       shut_q;
	duty_t      duty_q;
	logic       advance;
	logic       cool_wr;
	chain_res_t res;
	duty_t      duty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hot_limit     <= 12'd0;
			cfg_q.cool_limit    <= 12'd4095;
			cfg_q.danger        <= 12'd0;
			cfg_q.target        <= 12'd2048;
			cfg_q.default_speed <= 7'd100;
			cfg_q.pwm_inverted  <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HOT_LIMIT:     cfg_q.hot_limit     <= cfg_data;
				REG_COOL_LIMIT:    cfg_q.cool_limit    <= cfg_data;
				REG_DANGER:        cfg_q.danger        <= cfg_data;
				REG_TARGET:        cfg_q.target        <= cfg_data;
				REG_DEFAULT_SPEED: cfg_q.default_speed <= cfg_data[SPEED_W-1:0];
				REG_PWM_INV:       cfg_q.pwm_inverted  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cool_wr = cfg_we && (reg_idx_t'(cfg_index) == REG_COOL_LIMIT);

	// Handshake: the input stage moves on when the result register is free or drained
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.chain_absent <= in_ch.chain_absent;
			item_s1.high_read_a  <= in_ch.high_read_a;
			item_s1.high_read_b  <= in_ch.high_read_b;
			item_s1.high_read_c  <= in_ch.high_read_c;
			item_s1.low_read_a   <= in_ch.low_read_a;
			item_s1.low_read_b   <= in_ch.low_read_b;
			item_s1.low_read_c   <= in_ch.low_read_c;
			item_s1.average_read <= in_ch.average_read;
			item_s1.round_end    <= in_ch.round_end;
		end
	end

	ctf_chain_eval u_eval (
		.item (item_s1),
		.cfg  (cfg_q),
		.res  (res)
	);

	ctf_regulator u_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.round_end (item_s1.round_end),
		.res       (res),
		.cfg       (cfg_q),
		.cool_wr   (cool_wr),
		.cool_data (cfg_data),
		.duty      (duty)
	);

	// Result register: load on advance, drop on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			err_q  <= res.error;
			shut_q <= res.shutdown;
			duty_q <= duty;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.chain_error    = err_q;
	assign out_ch.chain_shutdown = shut_q;
	assign out_ch.duty_valid     = duty_q.duty_valid;
	assign out_ch.fan_duty       = duty_q.fan_duty;

	a_no_duty_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !duty_q.duty_valid) |-> duty_q.fan_duty == '0)
		else $error("fan duty nonzero without a duty issue");

	a_err_no_shut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(err_q && shut_q))
		else $error("error chain flagged for shutdown");

	a_stage_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled report lost from input register");

endmodule

[design/ctf_chain_eval.sv]
// Chain checker: forms hot and cool figures of one report and checks the window.
// Pure compare logic; depends on ctf_pkg.
module ctf_chain_eval import ctf_pkg::*; (
	input  item_t      item,
	input  cfg_t       cfg,
	output chain_res_t res
);

	// Smallest (or largest) nonzero of three codes; zero unless two are nonzero
	function automatic logic [CODE_W-1:0] pick(input logic [CODE_W-1:0] a,
			input logic [CODE_W-1:0] b, input logic [CODE_W-1:0] c, input logic largest);
		logic [CODE_W-1:0] v [3];
		logic [CODE_W-1:0] best;
		logic              seen;
		logic              two;
		v[0] = a;
		v[1] = b;
		v[2] = c;
		best = '0;
		seen = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (v[i] != '0) begin
				if (!seen || (largest ? (v[i] > best) : (v[i] < best)))
					best = v[i];
				seen = 1'b1;
			end
		end
		two = ((a != '0) && (b != '0)) || ((a != '0) && (c != '0)) ||
			((b != '0) && (c != '0));
		return two ? best : '0;
	endfunction

	logic [CODE_W-1:0] hot_fig;
	logic [CODE_W-1:0] cool_fig;
	logic              out_hot;
	logic              out_avg;
	logic              out_cool;

	assign hot_fig  = pick(item.high_read_a, item.high_read_b, item.high_read_c, 1'b0);
	assign cool_fig = pick(item.low_read_a, item.low_read_b, item.low_read_c, 1'b1);

	// Window checks on hot figure, average and cool figure
	assign out_hot  = (hot_fig > cfg.cool_limit) || (hot_fig < cfg.hot_limit);
	assign out_avg  = (item.average_read > cfg.cool_limit) ||
		(item.average_read < cfg.hot_limit);
	assign out_cool = (cool_fig > cfg.cool_limit) || (cool_fig < cfg.hot_limit);

	always_comb begin
		res.error    = !item.chain_absent && (out_hot || out_avg || out_cool);
		res.update   = !item.chain_absent && !(out_hot || out_avg || out_cool);
		res.shutdown = res.update && (hot_fig < cfg.danger);
		res.hot      = hot_fig;
	end

endmodule

[design/ctf_regulator.sv]
// Fan regulator: keeps the round's hottest figure and steps the fan speed at round end.
// Holds the loop state registers; depends on ctf_pkg.
module ctf_regulator import ctf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              round_end,
	input  chain_res_t        res,
	input  cfg_t              cfg,
	input  logic              cool_wr,
	input  logic [CODE_W-1:0] cool_data,
	output duty_t             duty
);

	function automatic logic [CODE_W-1:0] absdiff(input logic [CODE_W-1:0] a,
			input logic [CODE_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [CODE_W-1:0]  round_hottest_q;
	logic [SPEED_W-1:0] fan_speed_q;
	logic [SPEED_W-1:0] issued_speed_q;
	logic [CODE_W-1:0]  issued_temp_q;
	logic [1:0]         hold_count_q;

	logic [CODE_W-1:0]  t;
	logic [SPEED_W-1:0] fs0;
	logic [SPEED_W-1:0] fs1;
	logic [SPEED_W-1:0] speed_dn;
	logic [SPEED_W-1:0] speed_up;
	logic [SPEED_W:0]   up_sum;
	logic               no_valid;
	logic               far;
	logic               held;
	logic               issue;

	// Round figure after this chain
	assign t = (res.update && (res.hot < round_hottest_q)) ? res.hot : round_hottest_q;

	// Load default speed when the stored speed is zero
	assign fs0 = (fan_speed_q != '0) ? fan_speed_q :
		((cfg.default_speed > MAX_SPEED) ? MAX_SPEED : cfg.default_speed);

	assign no_valid = (t == cfg.cool_limit) || (t == cfg.hot_limit);
	assign far      = absdiff(cfg.target, t) > DEADBAND;
	assign held     = far && (absdiff(t, issued_temp_q) < MOVE_MIN) &&
		(hold_count_q < HOLD_MAX);

	// Speed steps, clamped to the working range
	assign speed_dn = (fs0 > (MIN_SPEED + STEP_SPEED)) ? (fs0 - STEP_SPEED) : MIN_SPEED;
	assign up_sum   = {1'b0, fs0} + {1'b0, STEP_SPEED};
	assign speed_up = (up_sum < {1'b0, MAX_SPEED}) ? up_sum[SPEED_W-1:0] : MAX_SPEED;

	always_comb begin
		fs1 = fs0;
		if (far && !held) begin
			if (t > cfg.target)
				fs1 = speed_dn;
			else if (t < cfg.target)
				fs1 = speed_up;
		end
	end

	assign issue = !held && (fs1 != issued_speed_q);

	// Duty issued with this result
	always_comb begin
		duty.duty_valid = 1'b0;
		duty.fan_duty   = '0;
		if (round_end) begin
			if (no_valid) begin
				duty.duty_valid = 1'b1;
				duty.fan_duty   = polarity(cfg.pwm_inverted, MAX_SPEED);
			end else if (issue) begin
				duty.duty_valid = 1'b1;
				duty.fan_duty   = polarity(cfg.pwm_inverted, fs1);
			end
		end
	end

	// Advance loop state on each beat; reload the round figure on a cool limit write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_hottest_q <= 12'd4095;
			fan_speed_q     <= '0;
			issued_speed_q  <= '0;
			issued_temp_q   <= '0;
			hold_count_q    <= '0;
		end else if (cool_wr) begin
			round_hottest_q <= cool_data;
		end else if (step) begin
			if (round_end) begin
				round_hottest_q <= cfg.cool_limit;
				if (no_valid) begin
					fan_speed_q <= fs0;
				end else begin
					fan_speed_q <= fs1;
					if (held)
						hold_count_q <= hold_count_q + 2'd1;
					else if (far)
						hold_count_q <= '0;
					if (issue) begin
						issued_speed_q <= fs1;
						issued_temp_q  <= t;
					end
				end
			end else begin
				round_hottest_q <= t;
			end
		end
	end

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		fan_speed_q <= MAX_SPEED)
		else $error("fan speed above full scale");

	a_issued_range: assert property (@(posedge clk) disable iff (!arst_n)
		issued_speed_q <= MAX_SPEED)
		else $error("issued speed above full scale");

	a_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && round_end && !cool_wr && !no_valid && far && !held) |=> hold_count_q == '0)
		else $error("hold count not cleared on a speed step");

endmodule
